// ----- src/mwm_pkg.sv -----
// ----------------------------------------------------------------------------
// mwm_pkg - shared constants for the mecanum wheel mixer
// Fixed widths, register map and queue sizing used across the block.
// ----------------------------------------------------------------------------
package mwm_pkg;

  // four wheels, one sum each
  localparam int unsigned NUM_WHEELS = 4;

  // wheel speed limit register width and reset value
  localparam int unsigned LIMIT_W     = 15;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd8000;

  // result width and quotient width (quotient never exceeds the limit)
  localparam int unsigned OUT_W  = 16;
  localparam int unsigned QUOT_W = LIMIT_W;

  // queue between front and back end
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;

  // register map: word index lives above the byte offset
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 1;
  localparam int unsigned ADDR_W     = REG_IDX_W + 2;
  localparam logic [REG_IDX_W-1:0] REG_WHEEL_LIMIT = 1'b0;

endpackage

// ----- src/mwm_front.sv -----
// ----------------------------------------------------------------------------
// mwm_front - command mixing and peak classification
// Forms the four wheel sums and magnitudes, finds the peak, flags scaling.
// ----------------------------------------------------------------------------
module mwm_front #(
  parameter int unsigned CMD_WIDTH = 16,
  localparam int unsigned SW = CMD_WIDTH + 2,
  localparam int unsigned MW = CMD_WIDTH + 1,
  localparam int unsigned NW = mwm_pkg::NUM_WHEELS,
  localparam int unsigned LW = mwm_pkg::LIMIT_W,
  localparam int unsigned EW = NW * SW + NW * MW + MW + LW + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [CMD_WIDTH-1:0] move_x_i,
  input  logic signed [CMD_WIDTH-1:0] move_y_i,
  input  logic signed [CMD_WIDTH-1:0] turn_rate_i,
  input  logic        [LW-1:0]        limit_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic        [EW-1:0]        out_data_o
);

  localparam int unsigned MAG_OFF   = NW * SW;
  localparam int unsigned PEAK_OFF  = MAG_OFF + NW * MW;
  localparam int unsigned LIM_OFF   = PEAK_OFF + MW;
  localparam int unsigned SCALE_OFF = LIM_OFF + LW;
  localparam int unsigned CMP_W     = (MW > LW) ? MW : LW;

  logic signed [SW-1:0] xe, ye, we;
  logic signed [SW-1:0] sum_d [NW];
  logic        [MW-1:0] mag_d [NW];
  logic        [SW-1:0] neg   [NW];

  logic                 s1_vld_q, s2_vld_q;
  logic signed [SW-1:0] t1_q [NW];
  logic        [MW-1:0] m1_q [NW];
  logic        [LW-1:0] lim1_q;

  logic signed [SW-1:0] t2_q [NW];
  logic        [MW-1:0] m2_q [NW];
  logic        [LW-1:0] lim2_q;
  logic        [MW-1:0] peak2_q;
  logic                 scale2_q;

  logic        [MW-1:0] pk01, pk23, peak_d;
  logic                 scale_d;
  logic                 s1_ready, s2_ready;

  assign s2_ready   = !s2_vld_q || out_ready_i;
  assign s1_ready   = !s1_vld_q || s2_ready;
  assign in_ready_o = s1_ready;

  // stage 1: the four sums and their magnitudes
  always_comb begin
    xe = SW'(move_x_i);
    ye = SW'(move_y_i);
    we = SW'(turn_rate_i);
    sum_d[0] =  xe - ye + we;
    sum_d[1] =  xe + ye + we;
    sum_d[2] = -xe + ye + we;
    sum_d[3] = -xe - ye + we;
    for (int i = 0; i < NW; i++) begin
      neg[i]   = -sum_d[i];
      mag_d[i] = sum_d[i][SW-1] ? neg[i][MW-1:0] : sum_d[i][MW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_ready) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      t1_q   <= sum_d;
      m1_q   <= mag_d;
      lim1_q <= limit_i;
    end
  end

  // stage 2: peak over the four magnitudes, compare with limit
  always_comb begin
    pk01    = (m1_q[0] > m1_q[1]) ? m1_q[0] : m1_q[1];
    pk23    = (m1_q[2] > m1_q[3]) ? m1_q[2] : m1_q[3];
    peak_d  = (pk01 > pk23) ? pk01 : pk23;
    scale_d = CMP_W'(peak_d) > CMP_W'(lim1_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (s2_ready) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_vld_q) begin
      t2_q     <= t1_q;
      m2_q     <= m1_q;
      lim2_q   <= lim1_q;
      peak2_q  <= peak_d;
      scale2_q <= scale_d;
    end
  end

  // queue entry: {scale, limit, peak, magnitudes, sums}
  always_comb begin
    out_data_o = '0;
    for (int i = 0; i < NW; i++) begin
      out_data_o[i*SW +: SW]           = t2_q[i];
      out_data_o[MAG_OFF + i*MW +: MW] = m2_q[i];
    end
    out_data_o[PEAK_OFF +: MW] = peak2_q;
    out_data_o[LIM_OFF +: LW]  = lim2_q;
    out_data_o[SCALE_OFF]      = scale2_q;
  end

  assign out_valid_o = s2_vld_q;

endmodule

// ----- src/mwm_fifo.sv -----
// ----------------------------------------------------------------------------
// mwm_fifo - short item queue between front and back end
// Register-based FIFO; pointers wrap on their own since the depth is 2^n.
// ----------------------------------------------------------------------------
module mwm_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  localparam int unsigned PW = mwm_pkg::QUEUE_PTR_W;
  localparam int unsigned CW = PW + 1;

  logic [WIDTH-1:0] mem_q [mwm_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             full, empty, push, pop;

  assign full  = (cnt_q == CW'(mwm_pkg::QUEUE_DEPTH));
  assign empty = (cnt_q == '0);
  assign push  = wr_valid_i && !full;
  assign pop   = rd_ready_i && !empty;

  assign wr_ready_o = !full;
  assign rd_valid_o = !empty;
  assign rd_data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + 1'b1;
      if (pop)  rptr_q <= rptr_q + 1'b1;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

// ----- src/mwm_back.sv -----
// ----------------------------------------------------------------------------
// mwm_back - wheel scaling pipeline
// Multiplies each magnitude by the limit, then divides by the peak one
// quotient bit per stage; the last register holds the result item.
// ----------------------------------------------------------------------------
module mwm_back #(
  parameter int unsigned CMD_WIDTH = 16,
  localparam int unsigned SW = CMD_WIDTH + 2,
  localparam int unsigned MW = CMD_WIDTH + 1,
  localparam int unsigned NW = mwm_pkg::NUM_WHEELS,
  localparam int unsigned LW = mwm_pkg::LIMIT_W,
  localparam int unsigned OW = mwm_pkg::OUT_W,
  localparam int unsigned EW = NW * SW + NW * MW + MW + LW + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [EW-1:0]              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [NW-1:0][OW-1:0]      wheel_speed_o,
  output logic                       was_scaled_o
);

  localparam int unsigned MAG_OFF   = NW * SW;
  localparam int unsigned PEAK_OFF  = MAG_OFF + NW * MW;
  localparam int unsigned LIM_OFF   = PEAK_OFF + MW;
  localparam int unsigned SCALE_OFF = LIM_OFF + LW;
  localparam int unsigned QW        = mwm_pkg::QUOT_W;
  localparam int unsigned PW        = MW + LW;

  // stage 0 holds the product, stage k has resolved k quotient bits
  logic          vld_q   [QW+1];
  logic          scale_q [QW+1];
  logic [MW-1:0] peak_q  [QW+1];
  logic [PW-1:0] rem_q   [QW+1][NW];
  logic [QW-1:0] quo_q   [QW+1][NW];
  logic          sign_q  [QW+1][NW];
  logic [OW-1:0] pass_q  [QW+1][NW];

  logic                 out_vld_q;
  logic [NW-1:0][OW-1:0] wheel_q;
  logic                 scaled_q;

  logic                 adv;
  logic signed [SW-1:0] t_in   [NW];
  logic        [MW-1:0] m_in   [NW];
  logic        [LW-1:0] lim_in;

  logic [QW:0]   q_ext [NW];
  logic [QW:0]   q_neg [NW];

  // whole back end moves together when the result slot frees up
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    for (int i = 0; i < NW; i++) begin
      t_in[i] = $signed(in_data_i[i*SW +: SW]);
      m_in[i] = in_data_i[MAG_OFF + i*MW +: MW];
    end
    lim_in = in_data_i[LIM_OFF +: LW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
    end
  end

  // stage 0: |t| * limit per wheel
  always_ff @(posedge clk_i) begin
    if (adv) begin
      scale_q[0] <= in_data_i[SCALE_OFF];
      peak_q[0]  <= in_data_i[PEAK_OFF +: MW];
      for (int i = 0; i < NW; i++) begin
        rem_q[0][i]  <= PW'(m_in[i]) * PW'(lim_in);
        quo_q[0][i]  <= '0;
        sign_q[0][i] <= t_in[i][SW-1];
        pass_q[0][i] <= OW'(t_in[i]);
      end
    end
  end

  // restoring division; quotient <= limit so QW bits suffice
  for (genvar k = 1; k <= QW; k++) begin : g_div
    localparam int unsigned B = QW - k;

    logic [PW-1:0] sub;
    logic          ge   [NW];
    logic [PW-1:0] rem_d [NW];

    always_comb begin
      sub = PW'(peak_q[k-1]) << B;
      for (int i = 0; i < NW; i++) begin
        ge[i]    = rem_q[k-1][i] >= sub;
        rem_d[i] = ge[i] ? (rem_q[k-1][i] - sub) : rem_q[k-1][i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        scale_q[k] <= scale_q[k-1];
        peak_q[k]  <= peak_q[k-1];
        for (int i = 0; i < NW; i++) begin
          rem_q[k][i]  <= rem_d[i];
          quo_q[k][i]  <= {quo_q[k-1][i][QW-2:0], ge[i]};
          sign_q[k][i] <= sign_q[k-1][i];
          pass_q[k][i] <= pass_q[k-1][i];
        end
      end
    end
  end

  // result: signed quotient when scaled, raw sum otherwise
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      q_ext[i] = {1'b0, quo_q[QW][i]};
      q_neg[i] = -q_ext[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      scaled_q <= scale_q[QW];
      for (int i = 0; i < NW; i++) begin
        if (scale_q[QW]) begin
          wheel_q[i] <= OW'(sign_q[QW][i] ? q_neg[i] : q_ext[i]);
        end else begin
          wheel_q[i] <= pass_q[QW][i];
        end
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign wheel_speed_o = wheel_q;
  assign was_scaled_o  = scaled_q;

endmodule

// ----- src/mecanum_wheel_mixer.sv -----
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer - mecanum chassis mixer with wheel speed limiting
// Mixes a chassis command into four wheel speeds and, when the largest
// magnitude exceeds the limit, scales all wheels by limit/peak (truncated).
// ----------------------------------------------------------------------------
//
//  channel | handshake                    | payload
//  --------+------------------------------+-----------------------------------
//  cmd in  | in_valid_i / in_ready_o      | move_x_i, move_y_i, turn_rate_i
//  wheels  | out_valid_o / out_ready_i    | wheel_speed_0..3_o, was_scaled_o
//  config  | psel/penable/pwrite, pready  | paddr, pwdata, prdata
//
//  One item per cycle sustained while out_ready_i is held high. From accept
//  to result an item passes 2 front stages, the queue, the multiply stage,
//  15 divide stages (one quotient bit each, set by the 15-bit limit) and
//  the result register. Reset empties all stages and the queue and loads
//  the limit with 8000. A stalled result freezes the back end only; the
//  4-entry queue lets the front keep taking items until it fills.
//
module mecanum_wheel_mixer #(
  parameter int unsigned CMD_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,

  // command channel
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [CMD_WIDTH-1:0]            move_x_i,
  input  logic signed [CMD_WIDTH-1:0]            move_y_i,
  input  logic signed [CMD_WIDTH-1:0]            turn_rate_i,

  // wheel speed channel
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [mwm_pkg::OUT_W-1:0]       wheel_speed_0_o,
  output logic signed [mwm_pkg::OUT_W-1:0]       wheel_speed_1_o,
  output logic signed [mwm_pkg::OUT_W-1:0]       wheel_speed_2_o,
  output logic signed [mwm_pkg::OUT_W-1:0]       wheel_speed_3_o,
  output logic                                   was_scaled_o,

  // register port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [mwm_pkg::ADDR_W-1:0]             paddr,
  input  logic [mwm_pkg::APB_DATA_W-1:0]         pwdata,
  output logic [mwm_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                   pready
);

  localparam int unsigned SW = CMD_WIDTH + 2;
  localparam int unsigned MW = CMD_WIDTH + 1;
  localparam int unsigned NW = mwm_pkg::NUM_WHEELS;
  localparam int unsigned LW = mwm_pkg::LIMIT_W;
  localparam int unsigned OW = mwm_pkg::OUT_W;
  // queue entry: sums, magnitudes, peak, limit, scale flag
  localparam int unsigned EW = NW * SW + NW * MW + MW + LW + 1;

  // --------------------------------------------------------------------------
  // Register port. Only the word index is decoded; writes to other indexes
  // are dropped and read back as zero.
  // --------------------------------------------------------------------------
  logic [LW-1:0]                  limit_q;
  logic [mwm_pkg::REG_IDX_W-1:0]  reg_idx;
  logic                           limit_sel;

  assign reg_idx   = paddr[mwm_pkg::ADDR_W-1:2];
  assign limit_sel = (reg_idx == mwm_pkg::REG_WHEEL_LIMIT);
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= mwm_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && limit_sel) begin
      limit_q <= pwdata[LW-1:0];
    end
  end

  assign prdata = limit_sel ? mwm_pkg::APB_DATA_W'(limit_q) : '0;

  // --------------------------------------------------------------------------
  // Front end: sums, magnitudes, peak and the scale decision. The limit is
  // captured with the item, so it travels down with it.
  // --------------------------------------------------------------------------
  logic          fe_valid, fe_ready;
  logic [EW-1:0] fe_data;

  mwm_front #(
    .CMD_WIDTH (CMD_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .move_x_i    (move_x_i),
    .move_y_i    (move_y_i),
    .turn_rate_i (turn_rate_i),
    .limit_i     (limit_q),
    .out_valid_o (fe_valid),
    .out_ready_i (fe_ready),
    .out_data_o  (fe_data)
  );

  // --------------------------------------------------------------------------
  // Queue decouples front from back end stalls.
  // --------------------------------------------------------------------------
  logic          q_valid, q_ready;
  logic [EW-1:0] q_data;

  mwm_fifo #(
    .WIDTH (EW)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fe_valid),
    .wr_ready_o (fe_ready),
    .wr_data_i  (fe_data),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_data)
  );

  // --------------------------------------------------------------------------
  // Back end: multiply by the limit, divide by the peak, hold the result.
  // --------------------------------------------------------------------------
  logic [NW-1:0][OW-1:0] wheels;

  mwm_back #(
    .CMD_WIDTH (CMD_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (q_valid),
    .in_ready_o    (q_ready),
    .in_data_i     (q_data),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .wheel_speed_o (wheels),
    .was_scaled_o  (was_scaled_o)
  );

  assign wheel_speed_0_o = $signed(wheels[0]);
  assign wheel_speed_1_o = $signed(wheels[1]);
  assign wheel_speed_2_o = $signed(wheels[2]);
  assign wheel_speed_3_o = $signed(wheels[3]);

endmodule

// ----- dv/mecanum_wheel_mixer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer_tb - self-checking bench for the mecanum wheel mixer
// Drives chassis commands through the valid/ready channel and programs the
// wheel speed limit over the register port. Commands without a hand-worked
// result are mixed and normalized by a local model, and every returned wheel
// set is checked field by field, in order, under several limits and idle patterns.
// ----------------------------------------------------------------------------
module mecanum_wheel_mixer_tb;

  // one wheel set as the block returns it
  typedef struct packed {
    logic [mwm_pkg::NUM_WHEELS-1:0][mwm_pkg::OUT_W-1:0] speed;
    logic                                               scaled;
  } wheel_set_t;

  // directed stimulus row; known rows carry a hand-worked result
  typedef struct packed {
    logic [mwm_pkg::LIMIT_W-1:0] lim;
    logic [15:0]                 x;
    logic [15:0]                 y;
    logic [15:0]                 w;
    logic                        known;
    wheel_set_t                  want;
  } cmd_row_t;

  localparam int NUM_ROWS       = 21;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 150;
  localparam int MAX_SHOWN      = 10;
  localparam int SETTLE_CYCLES  = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [15:0] move_x_i    = '0;
  logic [15:0] move_y_i    = '0;
  logic [15:0] turn_rate_i = '0;

  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [mwm_pkg::OUT_W-1:0] wheel_speed_0_o;
  logic [mwm_pkg::OUT_W-1:0] wheel_speed_1_o;
  logic [mwm_pkg::OUT_W-1:0] wheel_speed_2_o;
  logic [mwm_pkg::OUT_W-1:0] wheel_speed_3_o;
  logic                      was_scaled_o;

  logic                           psel    = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite  = 1'b0;
  logic [mwm_pkg::ADDR_W-1:0]     paddr   = '0;
  logic [mwm_pkg::APB_DATA_W-1:0] pwdata  = '0;
  logic [mwm_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  // shadow of the limit register, only changed while the block is idle
  logic [mwm_pkg::LIMIT_W-1:0] cur_limit = mwm_pkg::LIMIT_RESET;

  wheel_set_t pending_wheels[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  cmd_row_t dir_rows [NUM_ROWS];

  mecanum_wheel_mixer #(
    .CMD_WIDTH(16)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .move_x_i       (move_x_i),
    .move_y_i       (move_y_i),
    .turn_rate_i    (turn_rate_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .wheel_speed_0_o(wheel_speed_0_o),
    .wheel_speed_1_o(wheel_speed_1_o),
    .wheel_speed_2_o(wheel_speed_2_o),
    .wheel_speed_3_o(wheel_speed_3_o),
    .was_scaled_o   (was_scaled_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Mixer model: exact wide sums, true magnitude for the peak, and
  // t*limit/peak truncated toward zero when the peak is over the limit.
  function automatic wheel_set_t mix_wheels(input logic [15:0] x, input logic [15:0] y,
                                            input logic [15:0] w,
                                            input logic [mwm_pkg::LIMIT_W-1:0] lim);
    longint sx;
    longint sy;
    longint sw;
    longint peak;
    longint mag;
    longint sum [mwm_pkg::NUM_WHEELS];
    wheel_set_t r;
    sx = longint'($signed(x));
    sy = longint'($signed(y));
    sw = longint'($signed(w));
    sum[0] = sx - sy + sw;
    sum[1] = sx + sy + sw;
    sum[2] = -sx + sy + sw;
    sum[3] = -sx - sy + sw;
    peak = 0;
    for (int i = 0; i < mwm_pkg::NUM_WHEELS; i++) begin
      mag = (sum[i] < 0) ? -sum[i] : sum[i];
      if (mag > peak) peak = mag;
    end
    r.scaled = (peak > longint'(lim));
    for (int i = 0; i < mwm_pkg::NUM_WHEELS; i++) begin
      if (r.scaled) begin
        mag = (sum[i] < 0) ? -sum[i] : sum[i];
        mag = (mag * longint'(lim)) / peak;
        sum[i] = (sum[i] < 0) ? -mag : mag;
      end
      r.speed[i] = 16'(sum[i]);
    end
    return r;
  endfunction

  function automatic cmd_row_t row(input int lim, input int x, input int y, input int w,
                                   input bit known, input int e0, input int e1,
                                   input int e2, input int e3, input bit sc);
    cmd_row_t r;
    r.lim          = mwm_pkg::LIMIT_W'(lim);
    r.x            = 16'(x);
    r.y            = 16'(y);
    r.w            = 16'(w);
    r.known        = known;
    r.want.speed[0] = 16'(e0);
    r.want.speed[1] = 16'(e1);
    r.want.speed[2] = 16'(e2);
    r.want.speed[3] = 16'(e3);
    r.want.scaled   = sc;
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("%t MISMATCH %s", $realtime, msg);
  endtask

  // Register write: setup cycle, then access until pready. Upper data bits
  // are random; only the low 15 belong to the limit.
  task automatic write_limit(input logic [mwm_pkg::LIMIT_W-1:0] lim);
    logic [mwm_pkg::APB_DATA_W-1:0] wd;
    wd = $urandom;
    wd[mwm_pkg::LIMIT_W-1:0] = lim;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {mwm_pkg::REG_WHEEL_LIMIT, 2'b00};
    pwdata  <= wd;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_limit = lim;
  endtask

  // Called right after a rising edge: drop valid and wait for every
  // outstanding wheel set to come back.
  task automatic drain_wheels();
    in_valid_i <= 1'b0;
    while (pending_wheels.size() != 0) @(posedge clk_i);
  endtask

  // Offer one command; returns on the rising edge that accepts it.
  // Handshakes are observed on the falling edge, where all signals are
  // settled for the coming rising edge.
  task automatic send_cmd(input logic [15:0] x, input logic [15:0] y,
                          input logic [15:0] w, input bit known,
                          input wheel_set_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    move_x_i    <= x;
    move_y_i    <= y;
    turn_rate_i <= w;
    do @(negedge clk_i); while (!in_ready_o);
    if (known) pending_wheels.push_back(want);
    else pending_wheels.push_back(mix_wheels(x, y, w, cur_limit));
    @(posedge clk_i);
  endtask

  // random receiver back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(negedge clk_i) begin
    wheel_set_t got;
    wheel_set_t exp_set;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.speed[0] = wheel_speed_0_o;
      got.speed[1] = wheel_speed_1_o;
      got.speed[2] = wheel_speed_2_o;
      got.speed[3] = wheel_speed_3_o;
      got.scaled   = was_scaled_o;
      if (pending_wheels.size() == 0) begin
        note_mismatch($sformatf("unexpected wheel set %0d %0d %0d %0d scaled %0b",
                                $signed(got.speed[0]), $signed(got.speed[1]),
                                $signed(got.speed[2]), $signed(got.speed[3]), got.scaled));
      end else begin
        exp_set = pending_wheels.pop_front();
        if (got !== exp_set) begin
          note_mismatch($sformatf(
            "wheels exp %0d %0d %0d %0d s%0b got %0d %0d %0d %0d s%0b",
            $signed(exp_set.speed[0]), $signed(exp_set.speed[1]),
            $signed(exp_set.speed[2]), $signed(exp_set.speed[3]), exp_set.scaled,
            $signed(got.speed[0]), $signed(got.speed[1]),
            $signed(got.speed[2]), $signed(got.speed[3]), got.scaled));
        end
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("mecanum_wheel_mixer verification failed");
    $finish;
  end

  initial begin
    logic [mwm_pkg::LIMIT_W-1:0] phase_lim [NUM_PHASES];
    logic [15:0] cmd [3];
    wheel_set_t none;
    int mode;
    int mag;
    none = '0;

    // Directed rows. Hand-worked ones: reset limit passes and scales, the
    // peak sitting exactly on the limit (no scaling) and one over it,
    // most negative commands, the full range limit, a limit of one with the
    // peak over it and on it, and a zero limit that flattens every
    // nonzero command while an all-zero command stays unscaled.
    dir_rows[0]  = row(8000, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    dir_rows[1]  = row(8000, 100, 20, 3, 1, 83, 123, -77, -117, 0);
    dir_rows[2]  = row(8000, 8000, 0, 0, 1, 8000, 8000, -8000, -8000, 0);
    dir_rows[3]  = row(8000, 8001, 0, 0, 1, 8000, 8000, -8000, -8000, 1);
    dir_rows[4]  = row(8000, 32767, 0, 0, 1, 8000, 8000, -8000, -8000, 1);
    dir_rows[5]  = row(8000, -32768, -32768, -32768, 1, -2666, -8000, -2666, 2666, 1);
    dir_rows[6]  = row(8000, 0, 0, -32768, 1, -8000, -8000, -8000, -8000, 1);
    dir_rows[7]  = row(8000, 0, 32767, 0, 1, -8000, 8000, 8000, -8000, 1);
    dir_rows[8]  = row(8000, 1234, -567, 89, 0, 0, 0, 0, 0, 0);
    dir_rows[9]  = row(8000, -1, -1, -1, 1, -1, -3, -1, 1, 0);
    dir_rows[10] = row(32767, 32767, 32767, 32767, 0, 0, 0, 0, 0, 0);
    dir_rows[11] = row(32767, -32768, 32767, -32768, 0, 0, 0, 0, 0, 0);
    dir_rows[12] = row(32767, 10000, 10000, 10000, 1, 10000, 30000, 10000, -10000, 0);
    dir_rows[13] = row(32767, 16384, 16384, 0, 0, 0, 0, 0, 0, 0);
    dir_rows[14] = row(1, 3, 0, 0, 1, 1, 1, -1, -1, 1);
    dir_rows[15] = row(1, 1, 0, 0, 1, 1, 1, -1, -1, 0);
    dir_rows[16] = row(1, 2, 1, 0, 0, 0, 0, 0, 0, 0);
    dir_rows[17] = row(0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    dir_rows[18] = row(0, 5, 0, 0, 1, 0, 0, 0, 0, 1);
    dir_rows[19] = row(0, -32768, 32767, -1, 1, 0, 0, 0, 0, 1);
    dir_rows[20] = row(8000, 300, -200, 100, 0, 0, 0, 0, 0, 0);

    phase_lim[0] = 15'd8000;
    phase_lim[1] = 15'd32767;
    phase_lim[2] = 15'd1;
    phase_lim[3] = 15'd20000;
    phase_lim[4] = 15'd0;
    phase_lim[5] = 15'd1500;
    phase_lim[6] = mwm_pkg::LIMIT_W'($urandom_range(1, 32767));
    phase_lim[7] = 15'd32767;

    // reset held low from the start, released once
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, no idling; limit changes only with the pipe empty
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (dir_rows[i].lim != cur_limit) begin
        drain_wheels();
        write_limit(dir_rows[i].lim);
      end
      send_cmd(dir_rows[i].x, dir_rows[i].y, dir_rows[i].w,
               dir_rows[i].known, dir_rows[i].want);
    end

    // random part: one limit per phase, idle pattern rotating
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_wheels();
      write_limit(phase_lim[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // hold off mid-phase until the pipe runs dry
        if (p == 2 && k == PHASE_ITEMS / 2) drain_wheels();
        mode = $urandom_range(3);
        for (int f = 0; f < 3; f++) begin
          case (mode)
            0: cmd[f] = 16'($urandom);
            1: begin
              // all three small: peak stays within the limit
              mag = $urandom_range(0, cur_limit / 3);
              cmd[f] = $urandom_range(1) ? 16'(-mag) : 16'(mag);
            end
            2: begin
              case ($urandom_range(5))
                0: cmd[f] = 16'h8000;
                1: cmd[f] = 16'h7fff;
                2: cmd[f] = 16'h0000;
                3: cmd[f] = 16'hffff;
                4: cmd[f] = 16'h0001;
                default: cmd[f] = 16'($urandom);
              endcase
            end
            default: begin
              // axis 0, sometimes more, right around the limit; the rest zero
              if (f == $urandom_range(2) || f == 0) begin
                mag = int'(cur_limit) + $urandom_range(2) - 1;
                if (mag > 32767) mag = 32767;
                if (mag < 0) mag = 0;
                cmd[f] = $urandom_range(1) ? 16'(-mag) : 16'(mag);
              end else begin
                cmd[f] = 16'h0000;
              end
            end
          endcase
        end
        send_cmd(cmd[0], cmd[1], cmd[2], 1'b0, none);
      end
    end

    drain_wheels();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_wheels.size() == 0) begin
      $display("mecanum_wheel_mixer verification clean");
    end else begin
      $display("mecanum_wheel_mixer verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/mwm_pkg.sv
src/mwm_front.sv
src/mwm_fifo.sv
src/mwm_back.sv
src/mecanum_wheel_mixer.sv
dv/mecanum_wheel_mixer_tb.sv
